// File: rtl/pjsq_pkg.sv
// ----------------------------------------------------------------------------
// pjsq_pkg: shared definitions for the per-joint motion segment queue
// Sizes, field widths, operation and status codes, and the structures that
// travel between the queue's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pjsq_pkg;

  // Queue geometry.
  localparam int JOINTS       = 6;
  localparam int QUEUE_DEPTH  = 8;
  localparam int CURVE_COUNT  = 8;
  localparam int CURVE_REGS   = 8;
  localparam int PACKET_BYTES = 9;
  localparam int SCALE_SHIFT  = 8;

  // Fixed field widths of the transactions.
  localparam int OP_W       = 2;
  localparam int JOINT_W    = 3;
  localparam int SIZE_W     = 8;
  localparam int CURVE_W    = 8;
  localparam int CURVE_ID_W = 3;
  localparam int VAL_W      = 16;
  localparam int DUR_W      = 32;
  localparam int STATUS_W   = 3;
  localparam int FREE_W     = 4;

  // Derived widths.
  localparam int JIDX_W    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W     = CNT_W + 1;
  localparam int ADDR_W    = JIDX_W + SLOT_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int CREG_W    = $clog2(CURVE_REGS);
  localparam int CFG_AW    = CREG_W + 2;
  localparam int CFG_DW    = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_BAD_JOINT = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_CURVE = 3'd4,
    ST_DISJOINT  = 3'd5,
    ST_POP_EMPTY = 3'd6
  } status_code_t;

  // One stored motion segment.
  typedef struct packed {
    logic [CURVE_ID_W-1:0] curve;
    logic [VAL_W-1:0]      shift;
    logic [VAL_W-1:0]      scale;
    logic [DUR_W-1:0]      dur;
  } seg_t;

  // Segment store write port.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    seg_t              data;
  } mem_wr_t;

  // Segment store read ports: tail slot on port a, head slot on port b.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } mem_rd_t;

  typedef logic [CURVE_REGS-1:0][CFG_DW-1:0] curve_ends_t;

  // Transaction held in the input register.
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [JIDX_W-1:0]  jidx;
    logic               joint_bad;
    logic [SIZE_W-1:0]  size;
    logic [CURVE_W-1:0] curve;
    logic [VAL_W-1:0]   shift;
    logic [VAL_W-1:0]   scale;
    logic [DUR_W-1:0]   dur;
    logic [CNT_W-1:0]   cnt;
    logic [SLOT_W-1:0]  head;
    logic [SLOT_W-1:0]  slot;
    logic               fwd_a;
    logic               fwd_b;
  } stage_t;

  // Result transaction.
  typedef struct packed {
    status_code_t          status;
    logic [CURVE_ID_W-1:0] head_curve;
    logic [VAL_W-1:0]      head_shift;
    logic [VAL_W-1:0]      head_scale;
    logic [DUR_W-1:0]      head_duration;
    logic [FREE_W-1:0]     free_slots;
    logic                  queue_empty;
    logic [VAL_W-1:0]      previous_end;
    logic [VAL_W-1:0]      new_start;
  } res_t;

  // Next ring position.
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pjsq_if.sv
// ----------------------------------------------------------------------------
// pjsq_if: command and result channels of the segment queue
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface pjsq_in_if;
  logic                             valid;
  logic                             ready;
  logic [pjsq_pkg::OP_W-1:0]        operation;
  logic [pjsq_pkg::JOINT_W-1:0]     joint;
  logic [pjsq_pkg::SIZE_W-1:0]      packet_size;
  logic [pjsq_pkg::CURVE_W-1:0]     curve_sel;
  logic signed [pjsq_pkg::VAL_W-1:0] shift_y;
  logic signed [pjsq_pkg::VAL_W-1:0] scale_y;
  logic [pjsq_pkg::DUR_W-1:0]       duration_us;

  modport source (
    output valid, operation, joint, packet_size, curve_sel, shift_y, scale_y,
           duration_us,
    input  ready
  );
  modport sink (
    input  valid, operation, joint, packet_size, curve_sel, shift_y, scale_y,
           duration_us,
    output ready
  );
endinterface

interface pjsq_out_if;
  logic                              valid;
  logic                              ready;
  logic [pjsq_pkg::STATUS_W-1:0]     status;
  logic [pjsq_pkg::CURVE_ID_W-1:0]   head_curve;
  logic signed [pjsq_pkg::VAL_W-1:0] head_shift;
  logic signed [pjsq_pkg::VAL_W-1:0] head_scale;
  logic [pjsq_pkg::DUR_W-1:0]        head_duration;
  logic [pjsq_pkg::FREE_W-1:0]       free_slots;
  logic                              queue_empty;
  logic signed [pjsq_pkg::VAL_W-1:0] previous_end;
  logic signed [pjsq_pkg::VAL_W-1:0] new_start;

  modport source (
    output valid, status, head_curve, head_shift, head_scale, head_duration,
           free_slots, queue_empty, previous_end, new_start,
    input  ready
  );
  modport sink (
    input  valid, status, head_curve, head_shift, head_scale, head_duration,
           free_slots, queue_empty, previous_end, new_start,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/per_joint_motion_segment_queue_unit.sv
// ----------------------------------------------------------------------------
// per_joint_motion_segment_queue_unit: per-joint ring of motion segments
//
// Commands enter on in_ch (push, pop or query for one joint) and every
// command yields exactly one result transaction on out_ch with the status,
// the head segment, the free slot count and the empty flag of that joint.
// The user must write curve endpoints through the cfg_ APB port only while
// no command is in flight; the block itself does not enforce this.
//
// An accepted command is held in the input register, and its result is then
// registered on out_ch. One command is taken per cycle unless out_ch stalls.
// The segment store reads the tail and head slots at acceptance; the check,
// the two endpoint multiplies and the queue update use the input register.
//
// When the receiver stalls, the result register holds and one more command
// can wait in the input register; in_ch.ready then falls until out_ch moves.
// Synchronous reset empties every queue and clears the curve registers;
// commands are accepted from the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module per_joint_motion_segment_queue_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  pjsq_in_if.sink                     in_ch,
  pjsq_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pjsq_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [pjsq_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [pjsq_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  localparam int CNT_W  = pjsq_pkg::CNT_W;
  localparam int SLOT_W = pjsq_pkg::SLOT_W;
  localparam int SUM_W  = pjsq_pkg::SUM_W;
  localparam int JIDX_W = pjsq_pkg::JIDX_W;
  localparam int VAL_W  = pjsq_pkg::VAL_W;

  pjsq_pkg::curve_ends_t curve_ends;

  // Queue bookkeeping per joint.
  logic [CNT_W-1:0]  cnt_r  [pjsq_pkg::JOINTS];
  logic [SLOT_W-1:0] head_r [pjsq_pkg::JOINTS];

  // Input register, forwarded write data and result register.
  pjsq_pkg::stage_t s1_r;
  pjsq_pkg::stage_t s1_nxt;
  logic             s1_valid_r;
  pjsq_pkg::seg_t   wdat_r;
  pjsq_pkg::res_t   res_r;
  pjsq_pkg::res_t   res_nxt;
  logic             out_valid_r;

  logic             s1_fire;
  logic             in_accept;

  pjsq_pkg::mem_wr_t mem_wr;
  pjsq_pkg::mem_rd_t mem_rd;
  pjsq_pkg::seg_t    rd_a;
  pjsq_pkg::seg_t    rd_b;

  // Check stage signals.
  pjsq_pkg::seg_t        tail_seg;
  pjsq_pkg::seg_t        head_seg;
  pjsq_pkg::seg_t        new_seg;
  pjsq_pkg::seg_t        show_seg;
  pjsq_pkg::status_code_t status;
  logic                 size_bad;
  logic                 q_full;
  logic                 curve_bad;
  logic                 disjoint;
  logic                 do_push;
  logic                 do_pop;
  logic [CNT_W-1:0]     cnt_after;
  logic [SLOT_W-1:0]    head_after;
  logic [VAL_W-1:0]     prev_end;
  logic [VAL_W-1:0]     new_start;
  logic [VAL_W-1:0]     pend;
  logic [VAL_W-1:0]     nbeg;

  // Acceptance side signals.
  logic                 in_jbad;
  logic [JIDX_W-1:0]    in_jidx;
  logic [CNT_W-1:0]     eff_cnt;
  logic [SLOT_W-1:0]    eff_head;
  logic [SUM_W-1:0]     end_sum;
  logic [SUM_W-1:0]     end_wrap;
  logic [SLOT_W-1:0]    new_slot;
  logic [SLOT_W-1:0]    tail_slot;
  logic [SLOT_W-1:0]    rdb_slot;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  pjsq_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .curve_ends (curve_ends)
  );

  // --------------------------------------------------------------------------
  // Handshake: the input register drains into the result register
  // --------------------------------------------------------------------------
  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_accept   = in_ch.valid && in_ch.ready;

  // --------------------------------------------------------------------------
  // Check stage: decide the command against the queue state it saw
  // --------------------------------------------------------------------------
  assign tail_seg = s1_r.fwd_a ? wdat_r : rd_a;
  assign head_seg = s1_r.fwd_b ? wdat_r : rd_b;
  assign new_seg  = '{curve: s1_r.curve[pjsq_pkg::CURVE_ID_W-1:0], shift: s1_r.shift,
                      scale: s1_r.scale, dur: s1_r.dur};

  assign size_bad  = (s1_r.op == pjsq_pkg::OP_PUSH) &&
                     (s1_r.size != pjsq_pkg::SIZE_W'(pjsq_pkg::PACKET_BYTES));
  assign q_full    = (s1_r.cnt == CNT_W'(pjsq_pkg::QUEUE_DEPTH));
  assign curve_bad = (s1_r.curve >= pjsq_pkg::CURVE_W'(pjsq_pkg::CURVE_COUNT));

  // End of the last queued segment and start of the pushed one.
  assign pend = curve_ends[tail_seg.curve][2*VAL_W-1:VAL_W];
  assign nbeg = curve_ends[s1_r.curve[pjsq_pkg::CURVE_ID_W-1:0]][VAL_W-1:0];

  pjsq_place u_prev (
    .endpoint (pend),
    .scale    (tail_seg.scale),
    .shift    (tail_seg.shift),
    .value    (prev_end)
  );

  pjsq_place u_next (
    .endpoint (nbeg),
    .scale    (s1_r.scale),
    .shift    (s1_r.shift),
    .value    (new_start)
  );

  assign disjoint = (s1_r.cnt != '0) && (prev_end != new_start);

  // Status in check order: size, joint, room, curve, continuity.
  always_comb begin
    status  = pjsq_pkg::ST_OK;
    do_push = 1'b0;
    do_pop  = 1'b0;
    if (size_bad) begin
      status = pjsq_pkg::ST_BAD_SIZE;
    end else if (s1_r.joint_bad) begin
      status = pjsq_pkg::ST_BAD_JOINT;
    end else begin
      case (s1_r.op)
        pjsq_pkg::OP_PUSH: begin
          if (q_full) begin
            status = pjsq_pkg::ST_FULL;
          end else if (curve_bad) begin
            status = pjsq_pkg::ST_BAD_CURVE;
          end else if (disjoint) begin
            status = pjsq_pkg::ST_DISJOINT;
          end else begin
            do_push = 1'b1;
          end
        end
        pjsq_pkg::OP_POP: begin
          if (s1_r.cnt == '0) begin
            status = pjsq_pkg::ST_POP_EMPTY;
          end else begin
            do_pop = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Queue state after the command.
  always_comb begin
    cnt_after  = s1_r.cnt;
    head_after = s1_r.head;
    if (do_push) begin
      cnt_after = s1_r.cnt + 1'b1;
    end else if (do_pop) begin
      cnt_after  = s1_r.cnt - 1'b1;
      head_after = pjsq_pkg::slot_inc(s1_r.head);
    end
  end

  // Head segment to report: nothing when empty, the pushed one when it is
  // the only segment, otherwise what the store read at the head.
  always_comb begin
    if (cnt_after == '0) begin
      show_seg = '0;
    end else if (do_push && (s1_r.cnt == '0)) begin
      show_seg = new_seg;
    end else begin
      show_seg = head_seg;
    end
  end

  // Result assembly; an invalid joint reports its status and zeros.
  always_comb begin
    res_nxt        = '0;
    res_nxt.status = status;
    if (!s1_r.joint_bad) begin
      res_nxt.head_curve    = show_seg.curve;
      res_nxt.head_shift    = show_seg.shift;
      res_nxt.head_scale    = show_seg.scale;
      res_nxt.head_duration = show_seg.dur;
      res_nxt.free_slots    = pjsq_pkg::FREE_W'(pjsq_pkg::QUEUE_DEPTH - int'(cnt_after));
      res_nxt.queue_empty   = (cnt_after == '0);
      if (status == pjsq_pkg::ST_DISJOINT) begin
        res_nxt.previous_end = prev_end;
        res_nxt.new_start    = new_start;
      end
    end
  end

  // Accepted pushes are appended at the ring end.
  assign mem_wr.en   = s1_fire && do_push;
  assign mem_wr.addr = {s1_r.jidx, s1_r.slot};
  assign mem_wr.data = new_seg;

  // Queue bookkeeping update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < pjsq_pkg::JOINTS; j++) begin
        cnt_r[j]  <= '0;
        head_r[j] <= '0;
      end
    end else if (s1_fire && !s1_r.joint_bad) begin
      cnt_r[s1_r.jidx]  <= cnt_after;
      head_r[s1_r.jidx] <= head_after;
    end
  end

  // --------------------------------------------------------------------------
  // Acceptance: read addresses from the state the previous command leaves
  // --------------------------------------------------------------------------
  assign in_jbad = ({1'b0, in_ch.joint} >= (pjsq_pkg::JOINT_W + 1)'(pjsq_pkg::JOINTS));
  assign in_jidx = in_jbad ? '0 : JIDX_W'(in_ch.joint);

  // Bypass the update the draining command makes to the same joint.
  always_comb begin
    if (s1_fire && !s1_r.joint_bad && (s1_r.jidx == in_jidx)) begin
      eff_cnt  = cnt_after;
      eff_head = head_after;
    end else begin
      eff_cnt  = cnt_r[in_jidx];
      eff_head = head_r[in_jidx];
    end
  end

  // Ring positions: slot after the tail, the tail, and the head to report.
  always_comb begin
    end_sum  = SUM_W'(eff_head) + SUM_W'(eff_cnt);
    end_wrap = (end_sum >= SUM_W'(pjsq_pkg::QUEUE_DEPTH)) ?
               end_sum - SUM_W'(pjsq_pkg::QUEUE_DEPTH) : end_sum;
    new_slot = end_wrap[SLOT_W-1:0];
    if (new_slot == '0) begin
      tail_slot = SLOT_W'(pjsq_pkg::QUEUE_DEPTH - 1);
    end else begin
      tail_slot = new_slot - 1'b1;
    end
    if ((in_ch.operation == pjsq_pkg::OP_POP) && (eff_cnt != '0)) begin
      rdb_slot = pjsq_pkg::slot_inc(eff_head);
    end else begin
      rdb_slot = eff_head;
    end
  end

  assign mem_rd.en     = in_accept;
  assign mem_rd.addr_a = {in_jidx, tail_slot};
  assign mem_rd.addr_b = {in_jidx, rdb_slot};

  always_comb begin
    s1_nxt           = s1_r;
    s1_nxt.op        = in_ch.operation;
    s1_nxt.jidx      = in_jidx;
    s1_nxt.joint_bad = in_jbad;
    s1_nxt.size      = in_ch.packet_size;
    s1_nxt.curve     = in_ch.curve_sel;
    s1_nxt.shift     = in_ch.shift_y;
    s1_nxt.scale     = in_ch.scale_y;
    s1_nxt.dur       = in_ch.duration_us;
    s1_nxt.cnt       = eff_cnt;
    s1_nxt.head      = eff_head;
    s1_nxt.slot      = new_slot;
    // A write landing on a slot being read this edge is taken from wdat_r.
    s1_nxt.fwd_a     = mem_wr.en && (mem_wr.addr == mem_rd.addr_a);
    s1_nxt.fwd_b     = mem_wr.en && (mem_wr.addr == mem_rd.addr_b);
  end

  pjsq_slot_mem u_mem (
    .clk  (clk),
    .wr   (mem_wr),
    .rd   (mem_rd),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r   <= s1_nxt;
      wdat_r <= mem_wr.data;
    end
  end

  // Input register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = res_r.status;
  assign out_ch.head_curve    = res_r.head_curve;
  assign out_ch.head_shift    = res_r.head_shift;
  assign out_ch.head_scale    = res_r.head_scale;
  assign out_ch.head_duration = res_r.head_duration;
  assign out_ch.free_slots    = res_r.free_slots;
  assign out_ch.queue_empty   = res_r.queue_empty;
  assign out_ch.previous_end  = res_r.previous_end;
  assign out_ch.new_start     = res_r.new_start;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // The empty flag and the free count describe the same queue.
  a_empty_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !(res_r.status == pjsq_pkg::ST_BAD_JOINT ||
                     (res_r.status == pjsq_pkg::ST_BAD_SIZE && res_r.free_slots == '0 &&
                      !res_r.queue_empty)) |->
      (res_r.queue_empty == (res_r.free_slots ==
                             pjsq_pkg::FREE_W'(pjsq_pkg::QUEUE_DEPTH))))
    else $error("empty flag disagrees with free slot count");

  // Computed endpoints are reported only for a continuity failure.
  a_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ((res_r.status == pjsq_pkg::ST_DISJOINT) ==
       (res_r.previous_end != res_r.new_start)))
    else $error("endpoint report does not match disjoint status");

  // An accepted push grows its joint's queue by one.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && do_push |=>
      (cnt_r[$past(s1_r.jidx)] == $past(s1_r.cnt) + 1'b1))
    else $error("push did not advance the entry count");

endmodule

`default_nettype wire

// File: rtl/pjsq_cfg_regs.sv
// ----------------------------------------------------------------------------
// pjsq_cfg_regs: curve endpoint registers behind an APB-style port
// Eight 32-bit registers, start value in the low half, end value in the high.
// ----------------------------------------------------------------------------
`default_nettype none

module pjsq_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pjsq_pkg::CFG_AW-1:0]     paddr,
  input  logic [pjsq_pkg::CFG_DW-1:0]     pwdata,
  output logic [pjsq_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready,
  output pjsq_pkg::curve_ends_t           curve_ends
);

  pjsq_pkg::curve_ends_t              curve_r;
  logic [pjsq_pkg::CREG_W-1:0]        reg_idx;

  // Registers are word aligned.
  assign reg_idx = paddr[pjsq_pkg::CFG_AW-1:2];

  // Register write in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_r <= '0;
    end else if (psel && penable && pwrite) begin
      curve_r[reg_idx] <= pwdata;
    end
  end

  assign pready     = 1'b1;
  assign prdata     = curve_r[reg_idx];
  assign curve_ends = curve_r;

endmodule

`default_nettype wire

// File: rtl/pjsq_slot_mem.sv
// ----------------------------------------------------------------------------
// pjsq_slot_mem: segment store for all joint rings
// One write port and two registered read ports, addressed {joint, slot}.
// ----------------------------------------------------------------------------
`default_nettype none

module pjsq_slot_mem (
  input  logic              clk,
  input  pjsq_pkg::mem_wr_t wr,
  input  pjsq_pkg::mem_rd_t rd,
  output pjsq_pkg::seg_t    rd_a,
  output pjsq_pkg::seg_t    rd_b
);

  pjsq_pkg::seg_t mem_r [pjsq_pkg::MEM_DEPTH];
  pjsq_pkg::seg_t rd_a_r;
  pjsq_pkg::seg_t rd_b_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  // Read ports; data is held while no read is issued.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_a_r <= mem_r[rd.addr_a];
      rd_b_r <= mem_r[rd.addr_b];
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

`default_nettype wire

// File: rtl/pjsq_place.sv
// ----------------------------------------------------------------------------
// pjsq_place: places a curve endpoint with a segment's scale and shift
// Computes endpoint*scale/256, truncated toward zero, plus shift, in 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pjsq_place (
  input  logic signed [pjsq_pkg::VAL_W-1:0] endpoint,
  input  logic signed [pjsq_pkg::VAL_W-1:0] scale,
  input  logic signed [pjsq_pkg::VAL_W-1:0] shift,
  output logic [pjsq_pkg::VAL_W-1:0]        value
);

  localparam int PROD_W = 2 * pjsq_pkg::VAL_W;
  localparam int SH     = pjsq_pkg::SCALE_SHIFT;

  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        biased;

  // Negative products get a bias so the shift rounds toward zero.
  assign prod   = endpoint * scale;
  assign biased = prod + {{(PROD_W - SH){1'b0}}, {SH{prod[PROD_W-1]}}};
  assign value  = biased[SH + pjsq_pkg::VAL_W - 1:SH] + shift;

endmodule

`default_nettype wire
